// ===== rtl/id3fx_pkg.sv =====
// id3fx_pkg: types and constants for the id3v2 frame extractor
// holds the parse phase enum, item structs and field byte counts; no dependencies
`timescale 1ns / 1ps

package id3fx_pkg;

    // parse phases
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ID      = 3'd1,
        PH_SIZE    = 3'd2,
        PH_FLAGS   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    // byte counts of the fixed fields
    localparam logic [3:0] HEADER_BYTES = 4'd10;
    localparam logic [3:0] ID_BYTES     = 4'd4;
    localparam logic [3:0] SIZE_BYTES   = 4'd4;
    localparam logic [3:0] FLAG_BYTES   = 4'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W   = 2;
    localparam logic [1:0] CFG_TARGET_ID = 2'd0;
    localparam logic [1:0] CFG_SHOW_ALL  = 2'd1;

    // byte kinds
    localparam logic KIND_ID      = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0] tag_byte;
        logic       tag_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_kind;
        logic       frame_last;
    } out_item_t;

endpackage

// ===== rtl/id3v2_frame_extractor.sv =====
// id3v2_frame_extractor: walks the frames of an id3v2.3 tag one byte per item
// depends on id3fx_pkg for phase enum, item structs and constants
`timescale 1ns / 1ps

// Takes one tag byte per cycle and emits at most one byte per input item.
// Each accepted item updates the parse state and its result, if any, is
// registered in the output register at the same clock edge; a new item
// is accepted every cycle unless a finished result is still waiting and
// m_ready is low. Bytes are walked as a 10-byte tag header, then frames of a
// 4-byte id, a 4-byte big-endian size, 2 flag bytes and the payload. A zero
// byte in place of a frame id ends parsing until the next tag_start. With
// show_all set, every id byte and payload byte is emitted; otherwise only the
// payload of the first frame whose id equals target_id is emitted, and
// parsing stops after it. The user must write configuration through cfg_wr_en,
// cfg_index and cfg_wr_data only while idle; the block does not enforce this.
module id3v2_frame_extractor (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [id3fx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_wr_data,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  id3fx_pkg::in_item_t              s_item,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output id3fx_pkg::out_item_t             m_item
);

    // configuration registers
    logic [31:0] target_id_reg;
    logic        show_all_reg;

    // parse state
    id3fx_pkg::phase_t phase_reg, phase_next;
    logic [3:0]        count_reg, count_next;
    logic [31:0]       id_reg, id_next;
    logic [31:0]       left_reg, left_next;
    logic              sel_reg, sel_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    id3fx_pkg::out_item_t m_item_reg, m_item_next;

    logic accept;

    // per-item working values
    id3fx_pkg::phase_t cur_phase;
    logic [3:0]        cur_count;
    logic [31:0]       cur_id;
    logic [31:0]       cur_left;
    logic              cur_sel;
    logic [3:0]        count_inc;
    logic [31:0]       id_shifted;
    logic [31:0]       left_dec;
    logic              emit;
    logic [7:0]        b;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_id_reg <= '0;
            show_all_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                id3fx_pkg::CFG_TARGET_ID: target_id_reg <= cfg_wr_data;
                id3fx_pkg::CFG_SHOW_ALL:  show_all_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // parse step for one item
    always_comb begin
        b = s_item.tag_byte;
        if (s_item.tag_start) begin
            cur_phase = id3fx_pkg::PH_HEADER;
            cur_count = '0;
            cur_id    = '0;
            cur_left  = '0;
            cur_sel   = 1'b0;
        end else begin
            cur_phase = phase_reg;
            cur_count = count_reg;
            cur_id    = id_reg;
            cur_left  = left_reg;
            cur_sel   = sel_reg;
        end
        count_inc  = cur_count + 4'd1;
        id_shifted = {cur_id[23:0], b};
        left_dec   = cur_left - 32'd1;

        phase_next = cur_phase;
        count_next = cur_count;
        id_next    = cur_id;
        left_next  = cur_left;
        sel_next   = cur_sel;
        emit       = 1'b0;
        m_item_next.out_byte   = b;
        m_item_next.byte_kind  = id3fx_pkg::KIND_ID;
        m_item_next.frame_last = 1'b0;

        case (cur_phase)
            id3fx_pkg::PH_HEADER: begin
                count_next = count_inc;
                if (count_inc >= id3fx_pkg::HEADER_BYTES) begin
                    phase_next = id3fx_pkg::PH_ID;
                    count_next = '0;
                end
            end
            id3fx_pkg::PH_ID: begin
                if (cur_count == 4'd0 && b == 8'd0) begin
                    // zero byte where an id begins ends the tag
                    phase_next = id3fx_pkg::PH_DONE;
                end else begin
                    id_next    = id_shifted;
                    count_next = count_inc;
                    emit       = show_all_reg;
                    if (count_inc >= id3fx_pkg::ID_BYTES) begin
                        sel_next   = (id_shifted == target_id_reg);
                        phase_next = id3fx_pkg::PH_SIZE;
                        count_next = '0;
                        left_next  = '0;
                    end
                end
            end
            id3fx_pkg::PH_SIZE: begin
                left_next  = {cur_left[23:0], b};
                count_next = count_inc;
                if (count_inc >= id3fx_pkg::SIZE_BYTES) begin
                    phase_next = id3fx_pkg::PH_FLAGS;
                    count_next = '0;
                end
            end
            id3fx_pkg::PH_FLAGS: begin
                count_next = count_inc;
                if (count_inc >= id3fx_pkg::FLAG_BYTES) begin
                    count_next = '0;
                    if (cur_left == 32'd0) begin
                        // empty payload ends the frame here
                        phase_next = (!show_all_reg && cur_sel) ?
                                     id3fx_pkg::PH_DONE : id3fx_pkg::PH_ID;
                    end else begin
                        phase_next = id3fx_pkg::PH_PAYLOAD;
                    end
                end
            end
            id3fx_pkg::PH_PAYLOAD: begin
                left_next = left_dec;
                emit      = show_all_reg || cur_sel;
                m_item_next.byte_kind  = id3fx_pkg::KIND_PAYLOAD;
                m_item_next.frame_last = (left_dec == 32'd0);
                if (left_dec == 32'd0) begin
                    count_next = '0;
                    phase_next = (!show_all_reg && cur_sel) ?
                                 id3fx_pkg::PH_DONE : id3fx_pkg::PH_ID;
                end
            end
            default: ;
        endcase

        // result register handshake
        if (accept) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= id3fx_pkg::PH_HEADER;
            count_reg <= '0;
            id_reg    <= '0;
            left_reg  <= '0;
            sel_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            id_reg    <= id_next;
            left_reg  <= left_next;
            sel_reg   <= sel_next;
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule
